### design/mlqs_pkg.sv
// mlqs_pkg: shared types and constants of the multilevel queue scheduler
// no dependencies
`default_nettype none
package mlqs_pkg;
  localparam int unsigned MaxProcesses = 64;
  localparam int unsigned IdxW = $clog2(MaxProcesses);
  localparam int unsigned CntW = $clog2(MaxProcesses + 1);
  localparam logic [15:0] QuantumReset = 16'd4;

  localparam logic [1:0] CmdLoad   = 2'd0;
  localparam logic [1:0] CmdNext   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] ClsSystem      = 2'd0;
  localparam logic [1:0] ClsInteractive = 2'd1;
  localparam logic [1:0] ClsBackground  = 2'd2;
  localparam logic [1:0] ClsOther       = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pid;
    logic [1:0]  proc_class;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remaining;
  } req_t;

  typedef struct packed {
    logic        slice_valid;
    logic [15:0] out_pid;
    logic [1:0]  out_class;
    logic [15:0] run_time;
    logic [15:0] remaining_after;
    logic        all_done;
  } res_t;
endpackage
`default_nettype wire

### design/mlqs_front.sv
// mlqs_front: request input queue, drops unused commands
// depends on mlqs_pkg
`default_nettype none
module mlqs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire mlqs_pkg::req_t req_i,
  output logic               vld_o,
  output mlqs_pkg::req_t     req_o,
  input  wire logic          take_i
);
  import mlqs_pkg::*;
  // two entry queue
  req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic keep, wr, rd;

  assign full  = (cnt_q == 2'd2);
  assign keep  = (req_i.cmd == CmdLoad) || (req_i.cmd == CmdNext) || (req_i.cmd == CmdClear);
  assign wr    = push && !full && keep;
  assign vld_o = (cnt_q != 2'd0);
  assign rd    = take_i && vld_o;
  assign req_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### design/mlqs_back.sv
// mlqs_back: process table and scan sequencer issuing one slice or done report per next-slice request
// depends on mlqs_pkg
`default_nettype none
module mlqs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [15:0]    quantum_i,
  input  wire logic           vld_i,
  input  wire mlqs_pkg::req_t req_i,
  output logic                take_o,
  output logic                res_vld_o,
  output mlqs_pkg::res_t      res_o,
  input  wire logic           res_take_i
);
  import mlqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RD, S_EMIT, S_OUT
  } state_e;
  typedef enum logic [1:0] {
    PH_SYS, PH_INT, PH_BG, PH_DONE
  } phase_e;

  // table memories
  logic [15:0] pid_mem [MaxProcesses];
  logic [1:0]  cls_mem [MaxProcesses];
  logic [7:0]  pri_mem [MaxProcesses];
  logic [15:0] bst_mem [MaxProcesses];
  logic [15:0] rem_mem [MaxProcesses];
  logic [MaxProcesses-1:0] served_q;

  state_e state_q;
  phase_e phase_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cursor_q;
  logic [CntW-1:0] k_q;
  logic            wrap_q;
  logic            found_q;
  logic [IdxW-1:0] best_q;
  logic [7:0]      bpri_q;
  logic [15:0]     rd_pid_q, rd_bst_q, rd_rem_q;
  logic [1:0]      rd_cls_q;
  logic [1:0]      sc_cls_q;
  logic [7:0]      sc_pri_q;
  logic [15:0]     sc_rem_q;
  logic            sc_v_q;
  logic [IdxW-1:0] sc_idx_q;
  logic            sc_srv_q;
  res_t            res_q;
  logic [15:0]     q_eff, run;
  logic [IdxW-1:0] kidx;

  assign kidx      = k_q[IdxW-1:0];
  assign take_o    = (state_q == S_IDLE) && vld_i;
  assign res_vld_o = (state_q == S_OUT);
  assign res_o     = res_q;
  assign q_eff     = (quantum_i == 16'd0) ? 16'd1 : quantum_i;
  assign run       = (rd_rem_q > q_eff) ? q_eff : rd_rem_q;

  // memory writes: loads and round robin update
  always_ff @(posedge clk_i) begin
    if (take_o && req_i.cmd == CmdLoad && cnt_q < CntW'(MaxProcesses)) begin
      pid_mem[cnt_q[IdxW-1:0]] <= req_i.pid;
      cls_mem[cnt_q[IdxW-1:0]] <= req_i.proc_class;
      pri_mem[cnt_q[IdxW-1:0]] <= req_i.prio;
      bst_mem[cnt_q[IdxW-1:0]] <= req_i.burst;
      rem_mem[cnt_q[IdxW-1:0]] <= req_i.remaining;
    end else if (state_q == S_EMIT && phase_q == PH_INT) begin
      rem_mem[best_q] <= rd_rem_q - run;
    end
    // scan read port, one entry a cycle
    sc_cls_q <= cls_mem[kidx];
    sc_pri_q <= pri_mem[kidx];
    sc_rem_q <= rem_mem[kidx];
    sc_srv_q <= served_q[kidx];
    sc_idx_q <= kidx;
    // winner read port
    rd_pid_q <= pid_mem[best_q];
    rd_cls_q <= cls_mem[best_q];
    rd_bst_q <= bst_mem[best_q];
    rd_rem_q <= rem_mem[best_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_SYS;
      cnt_q    <= '0;
      cursor_q <= '0;
      served_q <= '0;
      k_q      <= '0;
      wrap_q   <= 1'b0;
      found_q  <= 1'b0;
      best_q   <= '0;
      bpri_q   <= '0;
      sc_v_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (take_o) begin
          case (req_i.cmd)
            CmdLoad: if (cnt_q < CntW'(MaxProcesses)) begin
              served_q[cnt_q[IdxW-1:0]] <= 1'b0;
              cnt_q <= cnt_q + 1'b1;
            end
            CmdClear: begin
              cnt_q <= '0; phase_q <= PH_SYS; cursor_q <= '0; served_q <= '0;
            end
            CmdNext: begin
              found_q <= 1'b0;
              wrap_q  <= 1'b0;
              sc_v_q  <= 1'b0;
              k_q     <= (phase_q == PH_SYS) ? '0 : cursor_q;
              state_q <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // pipelined scan: issue k_q, evaluate previous entry
          logic hit, stop;
          hit  = 1'b0;
          stop = 1'b0;
          if (sc_v_q) begin
            case (phase_q)
              PH_SYS: hit = (sc_cls_q == ClsSystem) && !sc_srv_q &&
                            (!found_q || sc_pri_q < bpri_q);
              PH_INT: hit = (sc_cls_q == ClsInteractive) && (sc_rem_q != 16'd0);
              PH_BG:  hit = sc_cls_q[1];
              default: hit = 1'b0;
            endcase
          end
          if (hit) begin
            found_q <= 1'b1;
            best_q  <= sc_idx_q;
            bpri_q  <= sc_pri_q;
          end
          if (hit && phase_q != PH_SYS) begin
            stop = 1'b1;
            sc_v_q <= 1'b0;
            state_q <= S_RD;
          end
          if (!stop) begin
            if (k_q < cnt_q) begin
              sc_v_q <= 1'b1;
              k_q    <= k_q + 1'b1;
            end else begin
              sc_v_q <= 1'b0;
              if (phase_q == PH_DONE) begin
                res_q   <= '{slice_valid: 1'b0, out_pid: '0, out_class: '0,
                            run_time: '0, remaining_after: '0, all_done: 1'b1};
                state_q <= S_OUT;
              end else if (!sc_v_q) begin
                // pass done
                if (found_q || hit) begin
                  state_q <= S_RD;
                end else if (phase_q == PH_INT && !wrap_q && cursor_q != '0) begin
                  wrap_q <= 1'b1;
                  k_q    <= '0;
                end else begin
                  case (phase_q)
                    PH_SYS:  phase_q <= PH_INT;
                    PH_INT:  phase_q <= PH_BG;
                    default: phase_q <= PH_DONE;
                  endcase
                  cursor_q <= '0;
                  wrap_q   <= 1'b0;
                  k_q      <= '0;
                end
              end
            end
          end
        end
        S_RD: state_q <= S_EMIT;
        S_EMIT: begin
          res_q.slice_valid <= 1'b1;
          res_q.out_pid     <= rd_pid_q;
          res_q.out_class   <= rd_cls_q[1] ? ClsBackground : rd_cls_q;
          res_q.all_done    <= 1'b0;
          case (phase_q)
            PH_SYS: begin
              served_q[best_q]      <= 1'b1;
              res_q.run_time        <= rd_bst_q;
              res_q.remaining_after <= '0;
            end
            PH_INT: begin
              res_q.run_time        <= run;
              res_q.remaining_after <= rd_rem_q - run;
              cursor_q              <= {1'b0, best_q} + 1'b1;
            end
            default: begin
              res_q.run_time        <= rd_bst_q;
              res_q.remaining_after <= '0;
              cursor_q              <= {1'b0, best_q} + 1'b1;
            end
          endcase
          state_q <= S_OUT;
        end
        S_OUT: if (res_take_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/multilevel_queue_scheduler_unit.sv
// multilevel_queue_scheduler_unit: top level of the scheduler
// depends on mlqs_pkg, mlqs_front, mlqs_back
`default_nettype none
// Requests enter a two-deep input queue (front); the back end owns a 64-entry
// process table held in memories and serves one request at a time. A load or
// clear completes without leaving the idle state and yields no result. A
// next-slice request scans the table one entry per cycle through a single read
// port, and a request may need up to four passes (round robin from the cursor
// and its wrap pass, or the system and round robin passes, then the background
// pass and the pass that ends in the done report); the winner is then read and
// the result built. The result is held in an output register until popped; the
// front queue keeps taking requests meanwhile. The cursor can sit at
// entry_count, past the last entry, which ends the background phase and sends
// round robin back to the first entry.
module multilevel_queue_scheduler_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire mlqs_pkg::req_t  req_i,
  output logic                 empty,
  input  wire logic            pop,
  output mlqs_pkg::res_t       res_o,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_data_i
);
  import mlqs_pkg::*;

  // quantum register
  logic [15:0] quantum_q;
  req_t        fq_req;
  logic        fq_vld, fq_take, res_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QuantumReset;
    else if (cfg_we_i) quantum_q <= cfg_data_i;
  end

  mlqs_front u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .vld_o(fq_vld), .req_o(fq_req), .take_i(fq_take)
  );

  mlqs_back u_back (
    .clk_i, .rst_ni, .quantum_i(quantum_q),
    .vld_i(fq_vld), .req_i(fq_req), .take_o(fq_take),
    .res_vld_o(res_vld), .res_o, .res_take_i(pop)
  );

  assign empty = !res_vld;

  // a result carries either a slice or the done report, never both
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.slice_valid != res_o.all_done)) else $error("slice and done");
  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o))) else $error("result changed");
  // done report carries zero data fields; the check covers run_time
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.all_done) |-> (res_o.run_time == 16'd0)) else $error("done nonzero");
endmodule
`default_nettype wire
